// ----- design/telemetry_frame_checker_core_assert.svh -----
// Assertion macros shared by the frame checker modules.
`ifndef TELEMETRY_FRAME_CHECKER_CORE_ASSERT_SVH
`define TELEMETRY_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame checker assertion failed");

`endif

// ----- design/tfc_pkg.sv -----
// Shared types, constants and the CRC byte update for the frame checker.
`default_nettype none
package tfc_pkg;

	localparam logic [7:0]  MAGIC_FIRST   = 8'hA5;
	localparam logic [7:0]  MAGIC_SECOND  = 8'h5A;
	localparam logic [7:0]  FRAME_VERSION = 8'h01;
	localparam int unsigned HEADER_BYTES  = 6;
	localparam int unsigned CRC_BYTES     = 2;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	localparam int unsigned POS_W   = 17;
	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

	// Header byte positions.
	localparam logic [2:0] HDR_MAGIC0  = 3'd0;
	localparam logic [2:0] HDR_MAGIC1  = 3'd1;
	localparam logic [2:0] HDR_VERSION = 3'd2;
	localparam logic [2:0] HDR_TYPE    = 3'd3;
	localparam logic [2:0] HDR_LEN_LO  = 3'd4;
	localparam logic [2:0] HDR_LEN_HI  = 3'd5;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_LEN_MISM   = 3'd3;
	localparam logic [2:0] ST_CRC_MISM   = 3'd4;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_SAMPLES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_METRICS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_LOG     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT     = 8'd3;
	localparam int unsigned CFG_DATA_W = 16;

	// Result queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [7:0]  type_code_samples;
		logic [7:0]  type_code_metrics;
		logic [7:0]  type_code_log;
		logic [15:0] crc_init;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [7:0]  packet_type;
		logic [15:0] payload_length;
		logic [15:0] received_crc;
		logic [2:0]  status;
		logic        run_last;
	} res_t;

	// Up to two result beats written into the queue in one cycle, item0 first.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       item0;
		res_t       item1;
	} push_t;

	// CRC16-CCITT, MSB first, one byte.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- design/tfc_cfg.sv -----
// Configuration register file of the frame checker.
`default_nettype none
module tfc_cfg
	import tfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid & cfg_ready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.type_code_samples <= 8'd0;
			cfg_q.type_code_metrics <= 8'd1;
			cfg_q.type_code_log     <= 8'd2;
			cfg_q.crc_init          <= 16'hFFFF;
		end else if (wr) begin
			case (cfg_index)
				REG_TYPE_SAMPLES: cfg_q.type_code_samples <= cfg_data[7:0];
				REG_TYPE_METRICS: cfg_q.type_code_metrics <= cfg_data[7:0];
				REG_TYPE_LOG:     cfg_q.type_code_log     <= cfg_data[7:0];
				REG_CRC_INIT:     cfg_q.crc_init          <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/tfc_check.sv -----
// Input register, frame state and per-byte check logic of the frame checker.
`default_nettype none
module tfc_check
	import tfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_buffer,
	input  wire cfg_t       cfg,
	input  wire logic       room,
	output push_t           push
);

	`include "telemetry_frame_checker_core_assert.svh"

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       type_q;
	logic [15:0]      len_q;
	logic [15:0]      rcrc_q;
	logic [15:0]      crc_q;
	logic             fault_q;

	logic             accept;
	logic             advance;
	logic [POS_W-1:0] pay_end;
	logic             in_hdr;
	logic             is_pay;
	logic [15:0]      crc_base;
	logic [15:0]      crc_new;
	logic [7:0]       type_new;
	logic [15:0]      len_new;
	logic [15:0]      rcrc_new;
	logic             fault_new;
	logic [POS_W-1:0] count;
	logic [2:0]       status;
	res_t             pay_item;
	res_t             ver_item;

	assign advance  = v_s1 & room;
	assign in_stall = v_s1 & ~room;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_buffer;
		end
	end

	assign pay_end  = {1'b0, len_q} + POS_W'(HEADER_BYTES);
	assign in_hdr   = pos_q < POS_W'(HEADER_BYTES);
	assign is_pay   = ~in_hdr & (pos_q < pay_end);
	assign crc_base = (pos_q == '0) ? cfg.crc_init : crc_q;
	assign crc_new  = (in_hdr | is_pay) ? crc_feed(crc_base, byte_s1) : crc_base;

	always_comb begin
		type_new  = type_q;
		len_new   = len_q;
		fault_new = fault_q;
		rcrc_new  = rcrc_q;
		if (in_hdr) begin
			case (pos_q[2:0])
				HDR_MAGIC0:  if (byte_s1 != MAGIC_FIRST) fault_new = 1'b1;
				HDR_MAGIC1:  if (byte_s1 != MAGIC_SECOND) fault_new = 1'b1;
				HDR_VERSION: if (byte_s1 != FRAME_VERSION) fault_new = 1'b1;
				HDR_TYPE: begin
					type_new = byte_s1;
					if (byte_s1 != cfg.type_code_samples && byte_s1 != cfg.type_code_metrics
							&& byte_s1 != cfg.type_code_log) begin
						fault_new = 1'b1;
					end
				end
				HDR_LEN_LO: len_new = {len_q[15:8], byte_s1};
				HDR_LEN_HI: len_new = {byte_s1, len_q[7:0]};
				default: ;
			endcase
		end else if (pos_q == pay_end) begin
			rcrc_new = {rcrc_q[15:8], byte_s1};
		end else if (pos_q == pay_end + POS_W'(1)) begin
			rcrc_new = {byte_s1, rcrc_q[7:0]};
		end
	end

	// Frame length in bytes, including this one; held at the counter ceiling.
	assign count = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);

	always_comb begin
		if (count < POS_W'(HEADER_BYTES + CRC_BYTES)) begin
			status = ST_TOO_SHORT;
		end else if (fault_new) begin
			status = ST_BAD_HEADER;
		end else if ({1'b0, count} != ({1'b0, pay_end} + (POS_W+1)'(CRC_BYTES))) begin
			status = ST_LEN_MISM;
		end else if (rcrc_new != crc_new) begin
			status = ST_CRC_MISM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		pay_item = '0;
		pay_item.kind = KIND_PAYLOAD;
		pay_item.payload_byte = byte_s1;
		pay_item.run_last = ~last_s1;

		ver_item = '0;
		ver_item.kind = KIND_VERDICT;
		ver_item.packet_type = type_new;
		ver_item.payload_length = len_new;
		ver_item.received_crc = rcrc_new;
		ver_item.status = status;
		ver_item.run_last = 1'b1;

		push = '0;
		if (advance) begin
			if (is_pay && last_s1) begin
				push.cnt = 2'd2;
				push.item0 = pay_item;
				push.item1 = ver_item;
			end else if (is_pay) begin
				push.cnt = 2'd1;
				push.item0 = pay_item;
			end else if (last_s1) begin
				push.cnt = 2'd1;
				push.item0 = ver_item;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			rcrc_q  <= '0;
			crc_q   <= 16'hFFFF;
			fault_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				type_q  <= '0;
				len_q   <= '0;
				rcrc_q  <= '0;
				crc_q   <= cfg.crc_init;
				fault_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				type_q  <= type_new;
				len_q   <= len_new;
				rcrc_q  <= rcrc_new;
				crc_q   <= crc_new;
				fault_q <= fault_new;
			end
		end
	end

	// A finished frame always restarts at position zero.
	`TFC_ASSERT_NXT(a_restart, clk, arst_n, advance && last_s1, pos_q == '0)
	// Two result beats come only from a frame that ends inside its payload.
	`TFC_ASSERT_IMP(a_two_beats, clk, arst_n, push.cnt == 2'd2,
		is_pay && last_s1 && push.item1.kind == KIND_VERDICT)

endmodule
`default_nettype wire

// ----- design/tfc_outq.sv -----
// Result queue of the frame checker: takes up to two beats a cycle, sends one while out_stall is low.
`default_nettype none
module tfc_outq
	import tfc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_stall,
	output res_t       head
);

	`include "telemetry_frame_checker_core_assert.svh"

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid & ~out_stall;
	assign head      = mem_q[rd_ptr_q];
	// Room for a full two-beat push regardless of what leaves this cycle.
	assign room      = cnt_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.cnt) - QCNT_W'(pop);
		end
	end

	`TFC_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
	`TFC_ASSERT_IMP(a_push_room, clk, arst_n, push.cnt != 2'd0, room)
	`TFC_ASSERT_NXT(a_cnt_track, clk, arst_n, 1'b1,
		cnt_q == $past(cnt_q) + QCNT_W'($past(push.cnt)) - QCNT_W'($past(pop)))

endmodule
`default_nettype wire

// ----- design/telemetry_frame_checker_core.sv -----
// Top level of the telemetry frame checker: byte in, payload and verdict beats out.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   data_byte, end_of_buffer
//  out      output     out_valid / out_stall kind, payload_byte, packet_type,
//                                            payload_length, received_crc, status, run_last
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input byte is accepted per cycle unless in_stall is high; its results pass through
// the input register and the result queue. A byte that ends a frame inside its payload gives
// two beats, sent one at a time on the single output port; the four-entry queue absorbs the extra.
// Reset clears the frame state and loads the register defaults; there is no clearing pass.
// The input stalls only while a byte waits in the input register and the result queue
// cannot take two more beats.
`default_nettype none
module telemetry_frame_checker_core
	import tfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  end_of_buffer,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       kind,
	output logic [7:0]                 payload_byte,
	output logic [7:0]                 packet_type,
	output logic [15:0]                payload_length,
	output logic [15:0]                received_crc,
	output logic [2:0]                 status,
	output logic                       run_last,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	push_t push;
	logic  room;
	res_t  head;

	tfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tfc_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.cfg           (cfg),
		.room          (room),
		.push          (push)
	);

	tfc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind           = head.kind;
	assign payload_byte   = head.payload_byte;
	assign packet_type    = head.packet_type;
	assign payload_length = head.payload_length;
	assign received_crc   = head.received_crc;
	assign status         = head.status;
	assign run_last       = head.run_last;

endmodule
`default_nettype wire
